### design/hme_pkg.sv
// Shared constants for the Heisenberg matrix element block.
// Used by the channel interfaces and by the top level; depends on nothing.
package hme_pkg;

  localparam int IDX_W     = 16;
  localparam int IDX_POS_W = $clog2(IDX_W);
  localparam int ELEM_W    = 6;
  localparam int CFG_W     = 3;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam int DEF_MAX_ROWS = 4;
  localparam int DEF_MAX_COLS = 4;

  localparam logic [CFG_W-1:0] GRID_ROWS_RESET = 3'd2;
  localparam logic [CFG_W-1:0] GRID_COLS_RESET = 3'd2;

  // Register index, taken from paddr bit 2.
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  // Element values in quarters.
  localparam logic signed [ELEM_W-1:0] ELEM_IDENTITY = 6'sd4;
  localparam logic signed [ELEM_W-1:0] ELEM_SWAP     = -6'sd2;
  localparam logic signed [ELEM_W-1:0] ELEM_ZERO     = 6'sd0;

endpackage

### design/hme_in_if.sv
// Input channel of the Heisenberg matrix element block: a pair of basis states.
// Depends on hme_pkg for the index width.
interface hme_in_if;
  logic                       valid;
  logic                       ready;
  logic [hme_pkg::IDX_W-1:0]  row_index;
  logic [hme_pkg::IDX_W-1:0]  col_index;

  modport source (output valid, output row_index, output col_index, input ready);
  modport sink   (input valid, input row_index, input col_index, output ready);
endinterface

### design/hme_out_if.sv
// Result channel of the Heisenberg matrix element block: one element in quarters.
// Depends on hme_pkg for the element width.
interface hme_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [hme_pkg::ELEM_W-1:0] element_quarters;
  logic                              is_diagonal;

  modport source (output valid, output element_quarters, output is_diagonal, input ready);
  modport sink   (input valid, input element_quarters, input is_diagonal, output ready);
endinterface

### design/heisenberg_matrix_element.sv
// Heisenberg matrix element block: one element of I - H per beat.
// Depends on hme_pkg, hme_in_if and hme_out_if.
//
// Usage: each input beat on in_ch carries a row and a column basis state, one
// spin bit per lattice site, site 0 in the most significant used bit. Each
// beat produces exactly one result beat on out_ch: the element of I - H in
// quarters and a flag that marks the diagonal. The lattice size is set by the
// grid_rows (address 0) and grid_cols (address 4) registers on the APB port;
// they are to be written only while the block is idle, which the block itself
// does not enforce. Sizes above MAX_ROWS / MAX_COLS saturate.
// An accepted input beat is held in the input register, then passes to the
// result register, whose output is the result beat. Throughput is one beat per
// cycle while the receiver takes results, set by the single combinational
// pass between those two registers. When the receiver stalls, the result
// register holds and the input register still takes one more beat; after
// that in_ch.ready drops.
// Synchronous reset empties both stages and sets the grid to 2 by 2.
module heisenberg_matrix_element #(
  parameter int MAX_ROWS = hme_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = hme_pkg::DEF_MAX_COLS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  hme_in_if.sink                      in_ch,
  hme_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [hme_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [hme_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [hme_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int MAX_SITES = MAX_ROWS * MAX_COLS;
  localparam int SITES_W   = $clog2(MAX_SITES + 1);
  localparam int NB        = MAX_ROWS * (MAX_COLS - 1) + MAX_COLS * (MAX_ROWS - 1);
  localparam int NBV       = NB + 1;
  localparam int CNT_W     = $clog2(NBV + 1);
  localparam int ACC_W     = CNT_W + hme_pkg::ELEM_W;
  localparam int PEXT_W    = SITES_W + hme_pkg::IDX_POS_W;
  localparam int DIM_W     = hme_pkg::CFG_W + 1;
  localparam logic [DIM_W-1:0] MAX_R = MAX_ROWS[DIM_W-1:0];
  localparam logic [DIM_W-1:0] MAX_C = MAX_COLS[DIM_W-1:0];

  // Configuration registers.
  logic [hme_pkg::CFG_W-1:0] grid_rows_r;
  logic [hme_pkg::CFG_W-1:0] grid_cols_r;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= hme_pkg::GRID_ROWS_RESET;
      grid_cols_r <= hme_pkg::GRID_COLS_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == hme_pkg::REG_GRID_ROWS) begin
        grid_rows_r <= cfg_pwdata[hme_pkg::CFG_W-1:0];
      end else begin
        grid_cols_r <= cfg_pwdata[hme_pkg::CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == hme_pkg::REG_GRID_COLS) begin
      cfg_prdata = {{(hme_pkg::APB_DW-hme_pkg::CFG_W){1'b0}}, grid_cols_r};
    end else begin
      cfg_prdata = {{(hme_pkg::APB_DW-hme_pkg::CFG_W){1'b0}}, grid_rows_r};
    end
  end

  // Two-stage pipeline handshake.
  logic                      s1_valid_r;
  logic [hme_pkg::IDX_W-1:0] s1_row_r;
  logic [hme_pkg::IDX_W-1:0] s1_col_r;
  logic                      out_valid_r;
  logic signed [hme_pkg::ELEM_W-1:0] out_elem_r;
  logic                      out_diag_r;
  logic                      adv2;
  logic                      adv1;

  assign adv2        = !out_valid_r || out_ch.ready;
  assign adv1        = !s1_valid_r || adv2;
  assign in_ch.ready = adv1;

  // Effective lattice size and site count.
  logic [DIM_W-1:0]     rows_eff;
  logic [DIM_W-1:0]     cols_eff;
  logic [2*DIM_W-1:0]   sites_prod;
  logic [SITES_W-1:0]   sites;

  assign rows_eff   = ({1'b0, grid_rows_r} > MAX_R) ? MAX_R : {1'b0, grid_rows_r};
  assign cols_eff   = ({1'b0, grid_cols_r} > MAX_C) ? MAX_C : {1'b0, grid_cols_r};
  assign sites_prod = rows_eff * cols_eff;
  assign sites      = sites_prod[SITES_W-1:0];

  logic [hme_pkg::IDX_W-1:0] idx_mask;
  logic [hme_pkg::IDX_W-1:0] row_m;
  logic [hme_pkg::IDX_W-1:0] col_m;
  logic [hme_pkg::IDX_W-1:0] diff_m;
  logic                      diag_c;
  logic                      two_flips;

  always_comb begin
    for (int k = 0; k < hme_pkg::IDX_W; k++) begin
      idx_mask[k] = (k < int'(sites));
    end
  end

  assign row_m     = s1_row_r & idx_mask;
  assign col_m     = s1_col_r & idx_mask;
  assign diff_m    = row_m ^ col_m;
  assign diag_c    = (row_m == col_m);
  assign two_flips = ($countones(diff_m) == 2);

  // Spin and flip bit of every lattice position. A site whose bit lies above
  // the index width reads as spin down and never flips.
  logic r_spin [MAX_ROWS][MAX_COLS];
  logic d_spin [MAX_ROWS][MAX_COLS];

  always_comb begin
    logic [SITES_W-1:0] s_v;
    logic [SITES_W-1:0] p_v;
    logic [PEXT_W-1:0]  p_ext;
    logic               here;
    for (int i = 0; i < MAX_ROWS; i++) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        here  = (i < int'(rows_eff)) && (j < int'(cols_eff));
        s_v   = SITES_W'(i * int'(cols_eff) + j);
        p_v   = sites - SITES_W'(1) - s_v;
        p_ext = PEXT_W'(p_v);
        if (here && (int'(p_v) < hme_pkg::IDX_W)) begin
          r_spin[i][j] = row_m[p_ext[hme_pkg::IDX_POS_W-1:0]];
          d_spin[i][j] = diff_m[p_ext[hme_pkg::IDX_POS_W-1:0]];
        end else begin
          r_spin[i][j] = 1'b0;
          d_spin[i][j] = 1'b0;
        end
      end
    end
  end

  // Per-bond flags; the top bit is a spare that stays clear.
  logic [NBV-1:0] bond_on;
  logic [NBV-1:0] bond_eq;
  logic [NBV-1:0] bond_swap;

  always_comb begin
    int k;
    k         = 0;
    bond_on   = '0;
    bond_eq   = '0;
    bond_swap = '0;
    for (int i = 0; i < MAX_ROWS - 1; i++) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        bond_on[k]   = (i + 1 < int'(rows_eff)) && (j < int'(cols_eff));
        bond_eq[k]   = (r_spin[i][j] == r_spin[i+1][j]);
        bond_swap[k] = d_spin[i][j] && d_spin[i+1][j] && !bond_eq[k];
        k++;
      end
    end
    for (int i = 0; i < MAX_ROWS; i++) begin
      for (int j = 0; j < MAX_COLS - 1; j++) begin
        bond_on[k]   = (i < int'(rows_eff)) && (j + 1 < int'(cols_eff));
        bond_eq[k]   = (r_spin[i][j] == r_spin[i][j+1]);
        bond_swap[k] = d_spin[i][j] && d_spin[i][j+1] && !bond_eq[k];
        k++;
      end
    end
  end

  // Diagonal: 1 + (bonds - 2 * equal bonds) / 4, worked in quarters.
  logic [CNT_W-1:0]        n_bonds;
  logic [CNT_W-1:0]        n_equal;
  logic signed [ACC_W-1:0] diag_acc;
  logic                    swap_hit;
  logic signed [hme_pkg::ELEM_W-1:0] elem_c;

  assign n_bonds  = CNT_W'($countones(bond_on));
  assign n_equal  = CNT_W'($countones(bond_on & bond_eq));
  assign diag_acc = ACC_W'(hme_pkg::ELEM_IDENTITY) + ACC_W'(n_bonds)
                    - (ACC_W'(n_equal) <<< 1);
  assign swap_hit = two_flips && |(bond_on & bond_swap);

  always_comb begin
    if (diag_c) begin
      elem_c = diag_acc[hme_pkg::ELEM_W-1:0];
    end else if (swap_hit) begin
      elem_c = hme_pkg::ELEM_SWAP;
    end else begin
      elem_c = hme_pkg::ELEM_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_r <= in_ch.valid;
      end
      if (adv2) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_ch.valid) begin
      s1_row_r <= in_ch.row_index;
      s1_col_r <= in_ch.col_index;
    end
    if (adv2 && s1_valid_r) begin
      out_elem_r <= elem_c;
      out_diag_r <= diag_c;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.element_quarters = out_elem_r;
  assign out_ch.is_diagonal      = out_diag_r;

  // An off-diagonal element is either a single swap or zero.
  a_offdiag_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_diag_r) |->
      (out_elem_r == hme_pkg::ELEM_SWAP || out_elem_r == hme_pkg::ELEM_ZERO))
    else $error("off-diagonal element out of range");

  // An empty lattice makes every pair a diagonal of value one.
  a_empty_lattice: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && sites == '0) |-> (diag_c && elem_c == hme_pkg::ELEM_IDENTITY))
    else $error("empty lattice gave a wrong element");

  // A held first stage keeps its beat while the result register is stalled.
  a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv2) |=> (s1_valid_r && $stable(s1_row_r) && $stable(s1_col_r)))
    else $error("first stage lost a beat under stall");

  // An accepted input beat always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> s1_valid_r)
    else $error("accepted beat did not enter the pipeline");

endmodule
